// ===== sv/dpd_pkg.sv =====
// Shared types and constants for the debug packet deframer.
// No dependencies; imported by every module of the block.
package dpd_pkg;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_INTR  = 8'h03;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;

    localparam int unsigned LEN_W     = 11;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        KIND_BODY   = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_BAD    = 3'd2,
        KIND_INTR   = 3'd3,
        KIND_DROP   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ACK_NONE  = 2'd0,
        ACK_PLUS  = 2'd1,
        ACK_MINUS = 2'd2
    } t_ack;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        body_byte;
        logic [LEN_W-1:0]  body_length;
    } t_evt;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_qhead;

endpackage

// ===== sv/dpd_front.sv =====
// Front end: accepts received bytes, tracks the packet parse phase and
// classifies received bytes into events for the queue. Depends on dpd_pkg.
module dpd_front
    import dpd_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 1200
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_space,
    output logic       o_ready,
    output logic       o_push,
    output t_evt       o_evt
);

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } t_phase;

    localparam logic [LEN_W:0] LIMIT = (LEN_W + 1)'(BUFFER_BYTES);

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    t_phase           r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [LEN_W-1:0] r_count, n_count;
    logic [7:0]       r_expected, n_expected;
    logic             w_take;
    logic [4:0]       w_digit;
    logic [LEN_W:0]   w_count_inc;

    assign o_ready     = i_space;
    assign w_take      = i_valid && i_space;
    assign w_digit     = hex_digit(i_byte);
    assign w_count_inc = {1'b0, r_count} + (LEN_W + 1)'(1);

    always_comb begin
        n_phase    = r_phase;
        n_sum      = r_sum;
        n_count    = r_count;
        n_expected = r_expected;
        o_push     = 1'b0;
        o_evt      = '{kind: KIND_BODY, body_byte: 8'h00, body_length: '0};
        if (w_take) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_byte == CH_START) begin
                        n_phase = PH_BODY;
                        n_sum   = 8'h00;
                        n_count = '0;
                    end else if (i_byte == CH_INTR) begin
                        o_push     = 1'b1;
                        o_evt.kind = KIND_INTR;
                    end
                end
                PH_BODY: begin
                    if (i_byte == CH_END) begin
                        n_phase = PH_HI;
                    end else if (w_count_inc < LIMIT) begin
                        n_count         = w_count_inc[LEN_W-1:0];
                        n_sum           = r_sum + i_byte;
                        o_push          = 1'b1;
                        o_evt.body_byte = i_byte;
                    end else begin
                        n_phase    = PH_WAIT;
                        o_push     = 1'b1;
                        o_evt.kind = KIND_DROP;
                    end
                end
                PH_HI: begin
                    n_expected = w_digit[4] ? {w_digit[3:0], 4'h0} : 8'hF0;
                    n_phase    = PH_LO;
                end
                PH_LO: begin
                    n_expected        = w_digit[4] ? (r_expected | {4'h0, w_digit[3:0]})
                                                   : 8'hFF;
                    n_phase           = PH_WAIT;
                    o_push            = 1'b1;
                    o_evt.kind        = (n_expected == r_sum) ? KIND_ACCEPT : KIND_BAD;
                    o_evt.body_length = r_count;
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_sum      <= 8'h00;
            r_count    <= '0;
            r_expected <= 8'h00;
        end else begin
            r_phase    <= n_phase;
            r_sum      <= n_sum;
            r_count    <= n_count;
            r_expected <= n_expected;
        end
    end

    a_push_needs_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> w_take)
        else $error("event pushed without an accepted byte");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parse phase lost one-hot encoding");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < LIMIT)
        else $error("body count reached the buffer limit");

endmodule

// ===== sv/dpd_queue.sv =====
// Short event queue between the front end and the output stage.
// Depends on dpd_pkg for the event type and depth.
module dpd_queue
    import dpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_evt   i_evt,
    input  logic   i_pop,
    output logic   o_space,
    output t_qhead o_head
);

    t_evt              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_space    = (r_count != QCNT_W'(QDEPTH));
    assign o_head     = '{valid: (r_count != '0), evt: r_mem[r_rd_ptr]};

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

endmodule

// ===== sv/dpd_back.sv =====
// Output stage: pops queued events, forms the acknowledgement request and
// holds the result in the output register. Depends on dpd_pkg.
module dpd_back
    import dpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ack_disabled,
    input  t_qhead      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte,
    output logic [LEN_W-1:0] o_length,
    output logic [1:0]  o_ack
);

    logic             r_valid;
    t_kind            r_kind;
    logic [7:0]       r_byte;
    logic [LEN_W-1:0] r_length;
    t_ack             r_ack, n_ack;

    assign o_pop    = i_head.valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_byte   = r_byte;
    assign o_length = r_length;
    assign o_ack    = r_ack;

    always_comb begin
        n_ack = ACK_NONE;
        if (!i_ack_disabled) begin
            if (i_head.evt.kind == KIND_ACCEPT) begin
                n_ack = ACK_PLUS;
            end else if (i_head.evt.kind == KIND_BAD) begin
                n_ack = ACK_MINUS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_head.evt.kind;
            r_byte   <= i_head.evt.body_byte;
            r_length <= i_head.evt.body_length;
            r_ack    <= n_ack;
        end
    end

    a_ack_only_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ack != ACK_NONE) |-> (r_kind == KIND_ACCEPT || r_kind == KIND_BAD))
        else $error("acknowledgement request on a non-verdict event");

endmodule

// ===== sv/debug_packet_deframer_top.sv =====
// An event from a byte transfer passes the event queue, then the output register.
// Throughput: one byte per cycle; the front end stalls only when the four-entry
// event queue is full, which happens only after m_axis_tready has been held low.
// Reset: i_rst_n is synchronous, active low; it returns the parser to waiting for
// '$', empties the queue and output register, and clears ack_disabled.
module debug_packet_deframer_top
    import dpd_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 1200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [23:0] m_axis_tdata,   // body_byte[7:0], body_length[18:8],
                                        // ack_request[20:19], zero[23:21]
    output logic [2:0]  m_axis_tuser,   // event_kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    logic             r_ack_disabled;
    logic             w_space;
    logic             w_push;
    t_evt             w_evt;
    logic             w_pop;
    t_qhead           w_head;
    logic [7:0]       w_byte;
    logic [LEN_W-1:0] w_length;
    logic [1:0]       w_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_disabled <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_ack_disabled <= i_cfg_wr_data;
        end
    end

    dpd_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_space (w_space),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_evt   (w_evt)
    );

    dpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_evt),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_head  (w_head)
    );

    dpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ack_disabled (r_ack_disabled),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_kind         (m_axis_tuser),
        .o_byte         (w_byte),
        .o_length       (w_length),
        .o_ack          (w_ack)
    );

    assign m_axis_tdata = {3'b000, w_ack, w_length, w_byte};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for debug_packet_deframer_top: directed rows, then random stream traffic,
// with random waits on both sides, checked transfer by transfer against an in-bench
// model of the packet parser. Depends on dpd_pkg and the top-level RTL only.
module tb;
    import dpd_pkg::*;

    localparam int unsigned BUFFER_BYTES = 1200;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_ITEMS = 165;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_BODY    = 2'd1,
        PH_CSUM_HI = 2'd2,
        PH_CSUM_LO = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       body_byte;
        logic [LEN_W-1:0] body_length;
        t_ack             ack;
    } t_frame_event;

    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;
        logic         has_res;
        t_frame_event res;
    } t_stim_row;

    localparam t_frame_event NO_EVT = '{KIND_BODY, 8'h00, 11'd0, ACK_NONE};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;

    t_frame_event pending_events[$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           events_seen = 0;
    int           idle_cycles = 0;
    int           tx_streak = 0;
    int           rx_streak = 0;
    logic         rx_held = 1'b0;

    logic             ack_off = 1'b0;
    t_phase           phase = PH_WAIT;
    logic [7:0]       run_sum = 8'h00;
    logic [LEN_W-1:0] run_count = '0;
    logic [7:0]       csum_target = 8'h00;

    t_stim_row directed_rows [0:24] = '{
        '{8'h03,   1'b1, 1'b1, '{KIND_INTR,   8'h00, 11'd0, ACK_NONE}},
        '{CH_ACK,  1'b1, 1'b0, NO_EVT},
        '{8'h00,   1'b1, 1'b0, NO_EVT},
        '{8'hFF,   1'b1, 1'b0, NO_EVT},
        '{CH_START, 1'b1, 1'b0, NO_EVT},
        '{8'h00,   1'b1, 1'b1, '{KIND_BODY,   8'h00, 11'd0, ACK_NONE}},
        '{8'hFF,   1'b1, 1'b1, '{KIND_BODY,   8'hFF, 11'd0, ACK_NONE}},
        '{CH_START, 1'b1, 1'b1, '{KIND_BODY,  8'h24, 11'd0, ACK_NONE}},
        '{CH_END,  1'b1, 1'b0, NO_EVT},
        '{8'h32,   1'b1, 1'b0, NO_EVT},
        '{8'h33,   1'b1, 1'b1, '{KIND_ACCEPT, 8'h00, 11'd3, ACK_PLUS}},
        '{CH_START, 1'b0, 1'b0, NO_EVT},
        '{8'h41,   1'b0, 1'b0, NO_EVT},
        '{CH_END,  1'b0, 1'b0, NO_EVT},
        '{8'h67,   1'b0, 1'b0, NO_EVT},
        '{8'h31,   1'b1, 1'b1, '{KIND_BAD,    8'h00, 11'd1, ACK_MINUS}},
        '{CH_START, 1'b0, 1'b0, NO_EVT},
        '{CH_END,  1'b0, 1'b0, NO_EVT},
        '{8'h30,   1'b0, 1'b0, NO_EVT},
        '{8'h7A,   1'b1, 1'b1, '{KIND_BAD,    8'h00, 11'd0, ACK_MINUS}},
        '{CH_START, 1'b0, 1'b0, NO_EVT},
        '{8'hAF,   1'b0, 1'b0, NO_EVT},
        '{CH_END,  1'b0, 1'b0, NO_EVT},
        '{8'h61,   1'b0, 1'b0, NO_EVT},
        '{8'h46,   1'b0, 1'b0, NO_EVT}
    };

    debug_packet_deframer_top #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] edges [6];
        logic [7:0] c;
        edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        if ($urandom_range(0, 1) == 0) return edges[$urandom_range(0, 5)];
        do c = 8'($urandom_range(0, 255)); while (digit_value(c) >= 0);
        return c;
    endfunction

    task automatic deframe_predict(input logic [7:0] c, output logic has,
                                   output t_frame_event ev);
        int  d;
        logic good;
        has = 1'b0;
        ev = NO_EVT;
        case (phase)
            PH_WAIT: begin
                if (c == CH_START) begin
                    phase = PH_BODY;
                    run_count = '0;
                    run_sum = 8'h00;
                end else if (c == CH_INTR) begin
                    has = 1'b1;
                    ev = '{KIND_INTR, 8'h00, 11'd0, ACK_NONE};
                end
            end
            PH_BODY: begin
                if (c == CH_END) begin
                    phase = PH_CSUM_HI;
                end else if (int'(run_count) + 1 < int'(BUFFER_BYTES)) begin
                    run_count = run_count + 1'b1;
                    run_sum = run_sum + c;
                    has = 1'b1;
                    ev = '{KIND_BODY, c, 11'd0, ACK_NONE};
                end else begin
                    phase = PH_WAIT;
                    has = 1'b1;
                    ev = '{KIND_DROP, 8'h00, 11'd0, ACK_NONE};
                end
            end
            PH_CSUM_HI: begin
                d = digit_value(c);
                csum_target = (d < 0) ? 8'hF0 : {d[3:0], 4'h0};
                phase = PH_CSUM_LO;
            end
            default: begin
                d = digit_value(c);
                csum_target = (d < 0) ? 8'hFF : (csum_target | {4'h0, d[3:0]});
                good = (csum_target == run_sum);
                has = 1'b1;
                ev.kind = good ? KIND_ACCEPT : KIND_BAD;
                ev.body_byte = 8'h00;
                ev.body_length = run_count;
                ev.ack = ack_off ? ACK_NONE : (good ? ACK_PLUS : ACK_MINUS);
                phase = PH_WAIT;
            end
        endcase
    endtask

    task automatic draw_wait(inout int streak, output int cycles);
        if (streak > 0) begin
            streak--;
            cycles = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            streak = $urandom_range(8, 40);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 11);
        end
    endtask

    // Runs from one falling edge to the falling edge after the transfer.
    task automatic send_item(input logic [7:0] c, input logic typed, input logic typed_has,
                             input t_frame_event typed_ev);
        int           gap;
        logic         has;
        t_frame_event ev;
        draw_wait(tx_streak, gap);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = c;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        deframe_predict(c, has, ev);
        if (typed) begin
            has = typed_has;
            ev = typed_ev;
        end
        if (has) pending_events.push_back(ev);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int len, input int csum_mode);
        logic [7:0] b;
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'h00;
        send_item(CH_START, 1'b0, 1'b0, NO_EVT);
        for (int i = 0; i < len; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_END);
            sum = sum + b;
            send_item(b, 1'b0, 1'b0, NO_EVT);
        end
        send_item(CH_END, 1'b0, 1'b0, NO_EVT);
        if (csum_mode == 1) sum = sum ^ 8'($urandom_range(1, 255));
        hi = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
        if (csum_mode == 2) hi = non_hex_char();
        if (csum_mode == 3) lo = non_hex_char();
        send_item(hi, 1'b0, 1'b0, NO_EVT);
        send_item(lo, 1'b0, 1'b0, NO_EVT);
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ack_mode(input logic v);
        settle();
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        ack_off = v;
    endtask

    task automatic random_traffic(input int count);
        int   start;
        int   r;
        int   csum_mode;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                csum_mode = $urandom_range(0, 19);
                csum_mode = (csum_mode < 16) ? 0 : (csum_mode < 18) ? 1 : csum_mode - 16;
                send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(13, 60)
                                                       : $urandom_range(0, 12), csum_mode);
            end else if (r < 85) begin
                case ($urandom_range(0, 3))
                    0: b = CH_INTR;
                    1: b = CH_ACK;
                    2: b = CH_NAK;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_item(b, 1'b0, 1'b0, NO_EVT);
            end else begin
                send_item(CH_START, 1'b0, 1'b0, NO_EVT);
                repeat ($urandom_range(1, 8))
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_EVT);
            end
        end
    endtask

    initial begin
        logic modes [4];
        modes = '{1'b1, 1'b0, 1'b1, 1'b0};
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tvalid = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].rx, directed_rows[i].typed,
                      directed_rows[i].has_res, directed_rows[i].res);

        foreach (modes[p]) begin
            write_ack_mode(modes[p]);
            if (p == 1) begin
                send_frame(BUFFER_BYTES, 0);
            end
            random_traffic(PHASE_ITEMS);
        end

        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        int           gap;
        t_frame_event want;
        m_axis_tready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            draw_wait(rx_streak, gap);
            if (!rx_held && events_seen >= 150) begin
                gap = 400;
                rx_held = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            events_seen++;
            if (pending_events.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer: expected none, got kind %0d data %06h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.body_byte ||
                    m_axis_tdata[18:8] !== want.body_length ||
                    m_axis_tdata[20:19] !== want.ack || m_axis_tdata[23:21] !== 3'b000) begin
                    mismatches++;
                    $display("%0t: mismatch: expected kind %0d byte %02h len %0d ack %0d pad 0",
                             $time, want.kind, want.body_byte, want.body_length, want.ack);
                    $display("%0t: mismatch: actual   kind %0d byte %02h len %0d ack %0d pad %0d",
                             $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[18:8],
                             m_axis_tdata[20:19], m_axis_tdata[23:21]);
                end
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/dpd_pkg.sv
sv/dpd_front.sv
sv/dpd_queue.sv
sv/dpd_back.sv
sv/debug_packet_deframer_top.sv
bench/tb.sv
